// ===== rtl/lkvc_pkg.sv =====
`default_nettype none
package lkvc_pkg;

  // Number of cells when the top level is not told otherwise.
  localparam int ENTRIES_DEFAULT = 16;

  localparam int CAP_W = 5;
  localparam int DATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Register index, taken from byte address bit 2.
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic update;
    logic respond;
  } ctrl_cmd_t;

  typedef struct packed {
    logic stall;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/lkvc_req_if.sv =====
`default_nettype none
interface lkvc_req_if;
  logic valid;
  logic ready;
  logic command;
  logic signed [31:0] lookup_key;
  logic signed [31:0] write_value;

  modport source (output valid, command, lookup_key, write_value, input ready);
  modport sink (input valid, command, lookup_key, write_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/lkvc_rsp_if.sv =====
`default_nettype none
interface lkvc_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  logic signed [31:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink (input valid, hit, read_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement.
// Each request beat is a get or a put; each produces exactly one response
// beat carrying hit and read_value (stored value on a get hit, all ones on
// a get miss, zero for a put). A request passes through the accept step,
// a parallel key compare over all cells, the cell and recency
// update with the value RAM access, and the load of the response register.
// A new request is taken only once the last has loaded its response,
// which may still wait in the output register; if it is still held when
// the next response is due, that step stalls. Writing the capacity
// register (byte address 0) clears the store immediately; capacity zero
// acts as one and values above ENTRIES act as ENTRIES. Write configuration
// only while no request is in flight.
`default_nettype none
module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  lkvc_req_if.sink    req,
  lkvc_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lkvc_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic             cfg_write;
  logic             cfg_clear;
  ctrl_cmd_t        ctrl;
  dp_status_t       status;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_clear = cfg_write && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_clear) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, capacity} : '0;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .ctrl     (ctrl),
    .status   (status)
  );

  lkvc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .status         (status),
    .clear          (cfg_clear),
    .capacity       (capacity),
    .command        (req.command),
    .lookup_key     (req.lookup_key),
    .write_value    (req.write_value),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_read_value (rsp.read_value)
  );

  // One request in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in flight");

  // The update step always follows a key compare.
  a_update_after_match: assert property (@(posedge clk) disable iff (rst)
    ctrl.update |-> $past(ctrl.match))
    else $error("update without a preceding match");

  // A miss reports either the get miss value or a put's zero.
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.hit |-> (rsp.read_value == '0) ||
                              (rsp.read_value == $signed(MISS_VALUE)))
    else $error("miss response carries a stored value");

  // A new response is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.respond |-> !(rsp.valid && !rsp.ready))
    else $error("response register overwritten");

endmodule
`default_nettype wire

// ===== rtl/lkvc_ram.sv =====
`default_nettype none
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/lkvc_ctrl.sv =====
`default_nettype none
module lkvc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output lkvc_pkg::ctrl_cmd_t    ctrl,
  input  lkvc_pkg::dp_status_t   status
);
  import lkvc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MATCH;
      end
      ST_MATCH:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_RESP;
      ST_RESP: begin
        if (!status.stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctrl = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctrl.capture = in_valid;
      end
      ST_MATCH:  ctrl.match = 1'b1;
      ST_UPDATE: ctrl.update = 1'b1;
      ST_RESP:   ctrl.respond = !status.stall;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/lkvc_datapath.sv =====
`default_nettype none
module lkvc_datapath #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lkvc_pkg::ctrl_cmd_t         ctrl,
  output lkvc_pkg::dp_status_t        status,
  input  logic                        clear,
  input  logic [lkvc_pkg::CAP_W-1:0]  capacity,
  input  logic                        command,
  input  logic signed [31:0]          lookup_key,
  input  logic signed [31:0]          write_value,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic                        rsp_hit,
  output logic signed [31:0]          rsp_read_value
);
  import lkvc_pkg::*;

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int FW = (CW > CAP_W) ? CW + 1 : CAP_W + 1;

  // Cells: key and recency rank live in flops for the parallel match;
  // values sit in a RAM since only one is read per item.
  logic [DATA_W-1:0] key_cell [ENTRIES];
  logic [RW-1:0]     rank_cell [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [CW-1:0]     occ;

  logic              cmd_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] val_q;

  logic              hit_q;
  logic [RW-1:0]     hit_idx_q;
  logic [RW-1:0]     hit_rank_q;
  logic [RW-1:0]     vic_idx_q;

  logic [ENTRIES-1:0] match_vec;
  logic              hit_c;
  logic [RW-1:0]     hit_idx_c;
  logic [RW-1:0]     hit_rank_c;
  logic [RW-1:0]     vic_idx_c;

  logic [FW-1:0]     eff_cap;
  logic              full;
  logic              insert;
  logic              modify;
  logic [RW-1:0]     target;
  logic [CW-1:0]     r_sel;

  logic              ram_we;
  logic [DATA_W-1:0] ram_rdata;

  // Parallel compare over all cells; keys are unique, so at most one hits.
  // The victim is the live cell whose rank is the oldest one.
  always_comb begin
    hit_idx_c = '0;
    hit_rank_c = '0;
    vic_idx_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid[i] && (key_cell[i] == key_q);
      if (match_vec[i]) begin
        hit_idx_c = hit_idx_c | RW'(i);
        hit_rank_c = hit_rank_c | rank_cell[i];
      end
      if (valid[i] && (CW'(rank_cell[i]) == occ - CW'(1))) begin
        vic_idx_c = vic_idx_c | RW'(i);
      end
    end
    hit_c = |match_vec;
  end

  always_comb begin
    if (capacity == '0) begin
      eff_cap = FW'(1);
    end else if (FW'(capacity) > FW'(ENTRIES)) begin
      eff_cap = FW'(ENTRIES);
    end else begin
      eff_cap = FW'(capacity);
    end
    full = FW'(occ) >= eff_cap;
    insert = (cmd_q == CMD_PUT) && !hit_q;
    modify = hit_q || insert;
    // Cells fill in order and are never freed one by one, so the first
    // free cell is the one numbered by the occupancy.
    if (hit_q) begin
      target = hit_idx_q;
      r_sel = CW'(hit_rank_q);
    end else if (full) begin
      target = vic_idx_q;
      r_sel = occ - CW'(1);
    end else begin
      target = occ[RW-1:0];
      r_sel = occ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ <= '0;
    end else if (clear) begin
      valid <= '0;
      occ <= '0;
    end else if (ctrl.update && insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (RW'(i) == target) valid[i] <= 1'b1;
      end
      if (!full) occ <= occ + CW'(1);
    end
  end

  // The touched cell becomes rank zero; every live cell that was more
  // recent than it ages by one.
  always_ff @(posedge clk) begin
    if (ctrl.update && modify) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (RW'(i) == target) begin
          key_cell[i] <= key_q;
          rank_cell[i] <= '0;
        end else if (valid[i] && (CW'(rank_cell[i]) < r_sel)) begin
          rank_cell[i] <= rank_cell[i] + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q <= command;
      key_q <= lookup_key;
      val_q <= write_value;
    end
    if (ctrl.match) begin
      hit_q <= hit_c;
      hit_idx_q <= hit_idx_c;
      hit_rank_q <= hit_rank_c;
      vic_idx_q <= vic_idx_c;
    end
  end

  assign ram_we = ctrl.update && (cmd_q == CMD_PUT);

  lkvc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_values (
    .clk   (clk),
    .we    (ram_we),
    .waddr (target),
    .wdata (val_q),
    .raddr (hit_idx_q),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.respond) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.respond) begin
      rsp_hit <= hit_q;
      if (cmd_q == CMD_PUT) begin
        rsp_read_value <= '0;
      end else if (hit_q) begin
        rsp_read_value <= $signed(ram_rdata);
      end else begin
        rsp_read_value <= $signed(MISS_VALUE);
      end
    end
  end

  assign status.stall = rsp_valid && !rsp_ready;

endmodule
`default_nettype wire
